### rtl/core/bacps_pkg.sv
package bacps_pkg;

  localparam int DEFAULT_MAX_COLUMNS    = 256;
  localparam int DEFAULT_IMBALANCE_BITS = 11;

  localparam int INDEX_OUT_BITS = 8;
  localparam int COUNT_OUT_BITS = 11;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic pair;
    logic last;
  } bacps_ctl_t;

endpackage

### rtl/core/bacps_front.sv
module bacps_front #(
  parameter int MAX_COLUMNS    = bacps_pkg::DEFAULT_MAX_COLUMNS,
  parameter int IMBALANCE_BITS = bacps_pkg::DEFAULT_IMBALANCE_BITS,
  parameter int IndexBits      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [IMBALANCE_BITS-1:0]     imbalance_i,
  input  logic                          solved_i,
  input  logic                          last_column_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output bacps_pkg::bacps_ctl_t         ctl_o,
  output logic [IMBALANCE_BITS-1:0]     exch_o,
  output logic [IndexBits-1:0]          dist_o,
  output logic [IMBALANCE_BITS-1:0]     deficit_o,
  output logic [IndexBits-1:0]          donor_o,
  output logic [IndexBits-1:0]          recv_o
);
  import bacps_pkg::*;

  localparam int CountBits = $clog2(MAX_COLUMNS + 1);

  logic [CountBits-1:0]      cnt_q, cnt_d;
  logic [IndexBits-1:0]      prev_idx_q, prev_idx_d;
  logic [IMBALANCE_BITS-1:0] prev_imb_q, prev_imb_d;

  logic                      accept;
  logic                      in_range;
  logic                      first_col;
  logic                      keep;
  logic                      prev_rx;
  logic                      cur_rx;
  logic [IndexBits-1:0]      idx;
  logic [IMBALANCE_BITS-1:0] mag_prev;
  logic [IMBALANCE_BITS-1:0] mag_cur;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign in_range  = cnt_q < CountBits'(MAX_COLUMNS);
  assign first_col = cnt_q == '0;
  assign idx       = cnt_q[IndexBits-1:0];
  assign keep      = !(solved_i && (imbalance_i == '0));
  assign prev_rx   = prev_imb_q[IMBALANCE_BITS-1];
  assign cur_rx    = imbalance_i[IMBALANCE_BITS-1];

  // magnitudes, the most negative value wraps to its unsigned magnitude
  assign mag_prev = prev_rx ? (~prev_imb_q + 1'b1) : prev_imb_q;
  assign mag_cur  = cur_rx ? (~imbalance_i + 1'b1) : imbalance_i;

  always_comb begin
    ctl_o.pair = in_range && !first_col && keep && (prev_rx != cur_rx);
    ctl_o.last = last_column_i;
    exch_o     = (mag_prev < mag_cur) ? mag_prev : mag_cur;
    deficit_o  = prev_rx ? mag_prev : mag_cur;
    donor_o    = prev_rx ? idx : prev_idx_q;
    recv_o     = prev_rx ? prev_idx_q : idx;
    dist_o     = idx - prev_idx_q;
    q_push_o   = accept && (ctl_o.pair || last_column_i);
  end

  always_comb begin
    cnt_d      = cnt_q;
    prev_idx_d = prev_idx_q;
    prev_imb_d = prev_imb_q;
    if (accept) begin
      if (last_column_i) begin
        cnt_d = '0;
      end else if (in_range) begin
        cnt_d = cnt_q + 1'b1;
        if (first_col || keep) begin
          prev_idx_d = idx;
          prev_imb_d = imbalance_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_idx_q <= prev_idx_d;
    prev_imb_q <= prev_imb_d;
  end

endmodule

### rtl/core/bacps_queue.sv
module bacps_queue #(
  parameter int DataBits = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [DataBits-1:0] data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output logic [DataBits-1:0] data_o
);
  import bacps_pkg::*;

  localparam int PtrBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

  logic [DataBits-1:0]  slot_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 do_pop;

  assign full_o  = count_q == CountBits'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/bacps_back.sv
module bacps_back #(
  parameter int MAX_COLUMNS    = bacps_pkg::DEFAULT_MAX_COLUMNS,
  parameter int IMBALANCE_BITS = bacps_pkg::DEFAULT_IMBALANCE_BITS,
  parameter int IndexBits      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  output logic                                   q_pop_o,
  input  bacps_pkg::bacps_ctl_t                  ctl_i,
  input  logic [IMBALANCE_BITS-1:0]              exch_i,
  input  logic [IndexBits-1:0]                   dist_i,
  input  logic [IMBALANCE_BITS-1:0]              deficit_i,
  input  logic [IndexBits-1:0]                   donor_i,
  input  logic [IndexBits-1:0]                   recv_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   found_o,
  output logic [bacps_pkg::INDEX_OUT_BITS-1:0]   donor_col_o,
  output logic [bacps_pkg::INDEX_OUT_BITS-1:0]   receiver_col_o,
  output logic [bacps_pkg::COUNT_OUT_BITS-1:0]   exchanged_count_o
);
  import bacps_pkg::*;

  logic                      best_valid_q, best_valid_d;
  logic [IMBALANCE_BITS-1:0] best_exch_q, best_exch_d;
  logic [IndexBits-1:0]      best_dist_q, best_dist_d;
  logic [IMBALANCE_BITS-1:0] best_def_q, best_def_d;
  logic [IndexBits-1:0]      best_donor_q, best_donor_d;
  logic [IndexBits-1:0]      best_recv_q, best_recv_d;

  logic                      out_valid_q, out_valid_d;
  logic                      found_q, found_d;
  logic [INDEX_OUT_BITS-1:0] donor_q, donor_d;
  logic [INDEX_OUT_BITS-1:0] recv_q, recv_d;
  logic [COUNT_OUT_BITS-1:0] count_q, count_d;

  logic                      beats;
  logic                      take;
  logic                      emit;
  logic [IndexBits+INDEX_OUT_BITS-1:0]       donor_ext;
  logic [IndexBits+INDEX_OUT_BITS-1:0]       recv_ext;
  logic [IMBALANCE_BITS+COUNT_OUT_BITS-1:0]  exch_ext;

  assign q_pop_o = q_valid_i && (!ctl_i.last || !out_valid_q || !out_stall_i);

  // ranking: most exchanged, then shortest distance, then smallest deficit
  assign beats = !best_valid_q || (exch_i > best_exch_q) ||
                 ((exch_i == best_exch_q) &&
                  ((dist_i < best_dist_q) ||
                   ((dist_i == best_dist_q) && (deficit_i < best_def_q))));

  assign take = q_pop_o && ctl_i.pair && beats;
  assign emit = q_pop_o && ctl_i.last;

  always_comb begin
    best_valid_d = best_valid_q;
    best_exch_d  = best_exch_q;
    best_dist_d  = best_dist_q;
    best_def_d   = best_def_q;
    best_donor_d = best_donor_q;
    best_recv_d  = best_recv_q;
    if (take) begin
      best_valid_d = 1'b1;
      best_exch_d  = exch_i;
      best_dist_d  = dist_i;
      best_def_d   = deficit_i;
      best_donor_d = donor_i;
      best_recv_d  = recv_i;
    end

    donor_ext = {{INDEX_OUT_BITS{1'b0}}, best_donor_d};
    recv_ext  = {{INDEX_OUT_BITS{1'b0}}, best_recv_d};
    exch_ext  = {{COUNT_OUT_BITS{1'b0}}, best_exch_d};

    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    donor_d     = donor_q;
    recv_d      = recv_q;
    count_d     = count_q;
    if (emit) begin
      out_valid_d = 1'b1;
      found_d     = best_valid_d;
      if (best_valid_d) begin
        donor_d = donor_ext[INDEX_OUT_BITS-1:0];
        recv_d  = recv_ext[INDEX_OUT_BITS-1:0];
        count_d = exch_ext[COUNT_OUT_BITS-1:0];
      end else begin
        donor_d = '0;
        recv_d  = '0;
        count_d = '0;
      end
      best_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      best_valid_q <= best_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_exch_q  <= best_exch_d;
    best_dist_q  <= best_dist_d;
    best_def_q   <= best_def_d;
    best_donor_q <= best_donor_d;
    best_recv_q  <= best_recv_d;
    found_q      <= found_d;
    donor_q      <= donor_d;
    recv_q       <= recv_d;
    count_q      <= count_d;
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = found_q;
  assign donor_col_o       = donor_q;
  assign receiver_col_o    = recv_q;
  assign exchanged_count_o = count_q;

endmodule

### rtl/core/best_adjacent_column_pair_select_core.sv
// best adjacent column pair selector
// input channel: one grid column per item (imbalance, solved, last_column),
// columns of a row in order from index 0; in_valid_i / in_stall_o
// output channel: one result item per row, sent for the column marked last:
// found, donor and receiver index and exchanged count; out_valid_o / out_stall_i
// throughput: one column per cycle while in_stall_o is low; the front classifies
// a column against the previous kept column in the cycle it is accepted, the back
// ranks one queued pair per cycle against the running best
// result path: with the output free, a row's last column passes through the queue
// and its result is then registered in the output register
// a two-entry queue between front and back absorbs a stalled result, so
// columns keep flowing until the queue fills; in_stall_o is the queue's full flag
// a receiver stall holds the result in the output register, and later pairs
// queue up behind the next last column
// reset clears the column count, the held best pair and both channels;
// no clearing pass, the block accepts columns in the first cycle after reset
module best_adjacent_column_pair_select_core #(
  parameter int MAX_COLUMNS    = bacps_pkg::DEFAULT_MAX_COLUMNS,
  parameter int IMBALANCE_BITS = bacps_pkg::DEFAULT_IMBALANCE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [IMBALANCE_BITS-1:0]            imbalance_i,
  input  logic                                 solved_i,
  input  logic                                 last_column_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [bacps_pkg::INDEX_OUT_BITS-1:0] donor_col_o,
  output logic [bacps_pkg::INDEX_OUT_BITS-1:0] receiver_col_o,
  output logic [bacps_pkg::COUNT_OUT_BITS-1:0] exchanged_count_o
);
  import bacps_pkg::*;

  localparam int IndexBits = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CtlBits   = $bits(bacps_ctl_t);
  localparam int DataBits  = CtlBits + 2 * IMBALANCE_BITS + 3 * IndexBits;

  logic                      q_push;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_valid;
  logic [DataBits-1:0]       q_wdata;
  logic [DataBits-1:0]       q_rdata;

  bacps_ctl_t                f_ctl;
  logic [IMBALANCE_BITS-1:0] f_exch;
  logic [IndexBits-1:0]      f_dist;
  logic [IMBALANCE_BITS-1:0] f_def;
  logic [IndexBits-1:0]      f_donor;
  logic [IndexBits-1:0]      f_recv;

  bacps_ctl_t                q_ctl;
  logic [IMBALANCE_BITS-1:0] q_exch;
  logic [IndexBits-1:0]      q_dist;
  logic [IMBALANCE_BITS-1:0] q_def;
  logic [IndexBits-1:0]      q_donor;
  logic [IndexBits-1:0]      q_recv;

  bacps_front #(
    .MAX_COLUMNS    (MAX_COLUMNS),
    .IMBALANCE_BITS (IMBALANCE_BITS),
    .IndexBits      (IndexBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .imbalance_i   (imbalance_i),
    .solved_i      (solved_i),
    .last_column_i (last_column_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .ctl_o         (f_ctl),
    .exch_o        (f_exch),
    .dist_o        (f_dist),
    .deficit_o     (f_def),
    .donor_o       (f_donor),
    .recv_o        (f_recv)
  );

  assign q_wdata = {f_ctl, f_exch, f_dist, f_def, f_donor, f_recv};

  bacps_queue #(
    .DataBits (DataBits)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {q_ctl, q_exch, q_dist, q_def, q_donor, q_recv} = q_rdata;

  bacps_back #(
    .MAX_COLUMNS    (MAX_COLUMNS),
    .IMBALANCE_BITS (IMBALANCE_BITS),
    .IndexBits      (IndexBits)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_pop_o           (q_pop),
    .ctl_i             (q_ctl),
    .exch_i            (q_exch),
    .dist_i            (q_dist),
    .deficit_i         (q_def),
    .donor_i           (q_donor),
    .recv_i            (q_recv),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .found_o           (found_o),
    .donor_col_o       (donor_col_o),
    .receiver_col_o    (receiver_col_o),
    .exchanged_count_o (exchanged_count_o)
  );

`ifndef ASSERT_OFF
  a_no_queue_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full)
  ) else $error("column queue written while full");

  a_empty_result_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (donor_col_o == '0 && receiver_col_o == '0 && exchanged_count_o == '0)
  ) else $error("result without a pair carries nonzero fields");

  a_result_from_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_valid && q_pop && q_ctl.last)
  ) else $error("result raised without a last column leaving the queue");
`endif

endmodule
